>>> rtl/cbd_pkg.sv
`timescale 1ns / 1ps
package cbd_pkg;

    localparam int BYTE_BITS = 8;
    localparam int LEN_BITS  = 32;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [BYTE_BITS-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_TAB  = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_SP   = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_X_LC = 8'h78;
    localparam logic [BYTE_BITS-1:0] CHAR_X_UC = 8'h58;

    localparam logic [1:0] GAP_BYTES = 2'd2;

    typedef enum logic [6:0] {
        PH_LEAD   = 7'b0000001,
        PH_ZERO   = 7'b0000010,
        PH_DIGITS = 7'b0000100,
        PH_REST   = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_GAP    = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0]           action;
        logic [BYTE_BITS-1:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 out_valid;
        logic                 body_done;
        logic                 stream_error;
        logic [LEN_BITS-1:0]  body_length;
    } t_out;

    // {digit flag, value}
    function automatic logic [4:0] hex_digit(input logic [BYTE_BITS-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [BYTE_BITS-1:0] c);
        return (c == CHAR_SP) || (c inside {[CHAR_TAB:CHAR_CR]});
    endfunction

endpackage

>>> rtl/chunked_body_decoder.sv
`timescale 1ns / 1ps
// The result of an input transfer appears on the output register in the next cycle.
// Throughput: one byte per cycle; the phase machine and counters settle in a
// single pass, and a result waiting on a stalled output still lets the next
// byte in when the output is taken in the same cycle.
// Reset: synchronous active low; returns to the start of a size line, counts zero.
module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_size, n_size;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic [COUNT_BITS-1:0] r_decoded, n_decoded;
    logic                  r_cr, n_cr;
    logic [1:0]            r_gap, n_gap;
    logic [1:0]            gap_dec;
    logic                  r_out_valid;
    t_out                  r_out_data, n_out_data;

    logic                  accept;
    logic [4:0]            hex;
    logic [COUNT_BITS-1:0] size_add;
    logic [63:0]           decoded_ext;
    logic [BYTE_BITS-1:0]  c;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign c   = i_in_data.in_byte;
    assign hex = hex_digit(c);
    // Saturate once another digit would overflow; otherwise the low nibble is free.
    assign size_add = (r_size[COUNT_BITS-1 -: 4] != 4'd0) ? COUNT_MAX
                    : {r_size[COUNT_BITS-5:0], hex[3:0]};
    assign gap_dec  = (r_gap != 2'd0) ? r_gap - 2'd1 : r_gap;

    always_comb begin
        n_phase    = r_phase;
        n_size     = r_size;
        n_left     = r_left;
        n_decoded  = r_decoded;
        n_cr       = r_cr;
        n_gap      = r_gap;
        n_out_data = '0;
        case (i_in_data.action)
            ACT_START: begin
                n_phase   = PH_LEAD;
                n_size    = '0;
                n_left    = '0;
                n_decoded = '0;
                n_cr      = 1'b0;
                n_gap     = '0;
            end
            ACT_CLOSE: begin
                if (r_phase != PH_DONE) begin
                    n_out_data.stream_error = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            ACT_BYTE: begin
                case (r_phase)
                    PH_DATA: begin
                        n_out_data.out_byte  = c;
                        n_out_data.out_valid = 1'b1;
                        if (r_decoded != COUNT_MAX) begin
                            n_decoded = r_decoded + 1'b1;
                        end
                        if (r_left != '0) begin
                            n_left = r_left - 1'b1;
                        end
                        if (n_left == '0) begin
                            n_phase = PH_GAP;
                            n_gap   = GAP_BYTES;
                        end
                    end
                    PH_GAP: begin
                        n_gap = gap_dec;
                        if (gap_dec == 2'd0) begin
                            n_phase = PH_LEAD;
                            n_size  = '0;
                            n_cr    = 1'b0;
                        end
                    end
                    PH_LEAD, PH_ZERO, PH_DIGITS, PH_REST: begin
                        n_cr = (c == CHAR_CR);
                        if (c == CHAR_LF && r_cr) begin
                            if (r_size == '0) begin
                                n_phase = PH_DONE;
                                n_out_data.body_done = 1'b1;
                            end else begin
                                n_left  = r_size;
                                n_phase = PH_DATA;
                            end
                        end else begin
                            case (r_phase)
                                PH_LEAD: begin
                                    if (!is_space(c)) begin
                                        if (hex[4]) begin
                                            n_size  = size_add;
                                            n_phase = (hex[3:0] == 4'd0) ? PH_ZERO
                                                                         : PH_DIGITS;
                                        end else begin
                                            n_phase = PH_REST;
                                        end
                                    end
                                end
                                PH_ZERO: begin
                                    if (c == CHAR_X_LC || c == CHAR_X_UC) begin
                                        n_phase = PH_DIGITS;
                                    end else if (hex[4]) begin
                                        n_size  = size_add;
                                        n_phase = PH_DIGITS;
                                    end else begin
                                        n_phase = PH_REST;
                                    end
                                end
                                PH_DIGITS: begin
                                    if (hex[4]) begin
                                        n_size = size_add;
                                    end else begin
                                        n_phase = PH_REST;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
            default: ;
        endcase
        decoded_ext = 64'(n_decoded);
        n_out_data.body_length = (decoded_ext[63:LEN_BITS] != '0) ? '1
                               : decoded_ext[LEN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_size      <= '0;
            r_left      <= '0;
            r_decoded   <= '0;
            r_cr        <= 1'b0;
            r_gap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_size    <= n_size;
                r_left    <= n_left;
                r_decoded <= n_decoded;
                r_cr      <= n_cr;
                r_gap     <= n_gap;
            end
            if (o_in_ready) begin
                r_out_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

>>> rtl/cbd_checker.sv
`timescale 1ns / 1ps
module cbd_checker
    import cbd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // Stalled result holds until transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // An empty output register never blocks input.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.out_valid && o_out_data.body_done)
                     && !(o_out_data.stream_error
                          && (o_out_data.out_valid || o_out_data.body_done)))
        else $error("conflicting result flags");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_valid |-> o_out_data.out_byte == '0)
        else $error("stray data byte");

    // Every input transfer produces a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("result missing after transfer");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
